/* hw/rtl/permutation_unrank_factoradic_defines.svh */
// Assertion macros for the permutation unranking block.
`ifndef PERMUTATION_UNRANK_FACTORADIC_DEFINES_SVH
`define PERMUTATION_UNRANK_FACTORADIC_DEFINES_SVH

`ifndef SYNTHESIS
`define PUF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("puf assertion failed");
`define PUF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("puf assertion failed");
`else
`define PUF_ASSERT_SAME(lbl, ante, cons)
`define PUF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hw/rtl/puf_pkg.sv */
// Shared types, widths and factorial table for the permutation unranking block.
`timescale 1ns / 1ps
`default_nettype none
package puf_pkg;

    localparam int SYM_W           = 8;
    localparam int WORD_W          = 64;
    localparam int LEN_W           = 4;
    localparam int RANK_W          = 16;
    localparam int MAX_LETTERS_DEF = 8;
    localparam int FACT_N          = 9;

    localparam logic [RANK_W-1:0] FACT_TABLE [FACT_N] = '{
        16'd1, 16'd1, 16'd2, 16'd6, 16'd24, 16'd120, 16'd720, 16'd5040, 16'd40320
    };

    typedef struct packed {
        logic             vld;
        logic             ok;
        logic [LEN_W-1:0] len;
    } t_ctrl;

    function automatic logic [RANK_W:0] fact_of(input logic [LEN_W-1:0] n);
        logic [RANK_W:0] f;
        f = '1;
        if (n < LEN_W'(FACT_N)) begin
            f = {1'b0, FACT_TABLE[n]};
        end
        return f;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/puf_check.sv */
// Input stage: range check of length and rank, symbol pool load.
`timescale 1ns / 1ps
`default_nettype none
module puf_check import puf_pkg::*; #(
    parameter int MAX_LETTERS = MAX_LETTERS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_vld,
    input  wire logic [WORD_W-1:0]            i_letters,
    input  wire logic [LEN_W-1:0]             i_len,
    input  wire logic [RANK_W-1:0]            i_rank,
    output t_ctrl                             o_ctrl,
    output logic      [RANK_W-1:0]            o_rank,
    output logic      [SYM_W*MAX_LETTERS-1:0] o_pool,
    output logic      [SYM_W*MAX_LETTERS-1:0] o_res
);

    t_ctrl                            r_ctrl, n_ctrl;
    logic [RANK_W-1:0]                r_rank;
    logic [SYM_W*MAX_LETTERS-1:0]     r_pool;

    always_comb begin
        n_ctrl.vld = i_vld;
        n_ctrl.len = i_len;
        n_ctrl.ok  = (i_len != '0) && (i_len <= LEN_W'(MAX_LETTERS)) &&
                     ({1'b0, i_rank} < fact_of(i_len));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= n_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rank <= i_rank;
            r_pool <= i_letters[SYM_W*MAX_LETTERS-1:0];
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_rank = r_rank;
    assign o_pool = r_pool;
    assign o_res  = '0;

endmodule
`default_nettype wire

/* hw/rtl/puf_stage.sv */
// One output position: digit select by factorial compare, symbol pick and pool compaction.
`timescale 1ns / 1ps
`default_nettype none
module puf_stage import puf_pkg::*; #(
    parameter int MAX_LETTERS = MAX_LETTERS_DEF,
    parameter int POS         = 0
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire t_ctrl                        i_ctrl,
    input  wire logic [RANK_W-1:0]            i_rank,
    input  wire logic [SYM_W*MAX_LETTERS-1:0] i_pool,
    input  wire logic [SYM_W*MAX_LETTERS-1:0] i_res,
    output t_ctrl                             o_ctrl,
    output logic      [RANK_W-1:0]            o_rank,
    output logic      [SYM_W*MAX_LETTERS-1:0] o_pool,
    output logic      [SYM_W*MAX_LETTERS-1:0] o_res
);

    localparam int SEL_W = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
    localparam int POOL_W = SYM_W * MAX_LETTERS;

    t_ctrl                    r_ctrl;
    logic [RANK_W-1:0]        r_rank, n_rank;
    logic [POOL_W-1:0]        r_pool, n_pool;
    logic [POOL_W-1:0]        r_res, n_res;
    logic [POOL_W+SYM_W-1:0]  pool_ext;
    logic [LEN_W-1:0]         rem;
    logic [RANK_W:0]          fact;
    logic [RANK_W:0]          mult [MAX_LETTERS];
    logic [SEL_W-1:0]         sel;
    logic [SYM_W-1:0]         pick;
    logic                     active;

    always_comb begin
        rem    = i_ctrl.len - LEN_W'(POS);
        active = i_ctrl.ok && (LEN_W'(POS) < i_ctrl.len);
        fact   = fact_of(rem - LEN_W'(1));
        for (int k = 0; k < MAX_LETTERS; k++) begin
            mult[k] = (RANK_W+1)'(fact * k);
        end
        sel = '0;
        for (int k = 1; k < MAX_LETTERS; k++) begin
            if (({1'b0, i_rank} >= mult[k]) && (LEN_W'(k) < rem)) begin
                sel = SEL_W'(k);
            end
        end
        n_rank   = RANK_W'({1'b0, i_rank} - mult[sel]);
        pool_ext = {{SYM_W{1'b0}}, i_pool};
        pick     = i_pool[sel*SYM_W +: SYM_W];
        for (int k = 0; k < MAX_LETTERS; k++) begin
            if (SEL_W'(k) < sel) begin
                n_pool[k*SYM_W +: SYM_W] = pool_ext[k*SYM_W +: SYM_W];
            end else begin
                n_pool[k*SYM_W +: SYM_W] = pool_ext[(k+1)*SYM_W +: SYM_W];
            end
        end
        n_res = i_res;
        if (active) begin
            n_res[POS*SYM_W +: SYM_W] = pick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rank <= n_rank;
            r_pool <= n_pool;
            r_res  <= n_res;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_rank = r_rank;
    assign o_pool = r_pool;
    assign o_res  = r_res;

endmodule
`default_nettype wire

/* hw/rtl/permutation_unrank_factoradic.sv */
// Top level: factorial number system permutation unranker, one stage per output position.
// Structure: one check stage plus one register stage per position.
// Throughput: one request per cycle while the output is not stalled.
// A stall at the output holds every stage in place; nothing is dropped or repeated.
// Reset is synchronous, active low, and clears the valid bit of every stage.
`timescale 1ns / 1ps
`default_nettype none
`include "permutation_unrank_factoradic_defines.svh"
module permutation_unrank_factoradic import puf_pkg::*; #(
    parameter int MAX_LETTERS = MAX_LETTERS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [WORD_W-1:0] i_letters,
    input  wire logic [LEN_W-1:0]  i_word_length,
    input  wire logic [RANK_W-1:0] i_rank,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [WORD_W-1:0]      o_permuted,
    output logic [LEN_W-1:0]       o_out_length,
    output logic                   o_valid_res
);

    localparam int POOL_W = SYM_W * MAX_LETTERS;

    t_ctrl              ctrl [MAX_LETTERS+1];
    logic [RANK_W-1:0]  rank [MAX_LETTERS+1];
    logic [POOL_W-1:0]  pool [MAX_LETTERS+1];
    logic [POOL_W-1:0]  res  [MAX_LETTERS+1];
    logic               en;

    assign en      = !ctrl[MAX_LETTERS].vld || i_ready;
    assign o_ready = en;

    puf_check #(.MAX_LETTERS(MAX_LETTERS)) u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_vld     (i_valid),
        .i_letters (i_letters),
        .i_len     (i_word_length),
        .i_rank    (i_rank),
        .o_ctrl    (ctrl[0]),
        .o_rank    (rank[0]),
        .o_pool    (pool[0]),
        .o_res     (res[0])
    );

    for (genvar p = 0; p < MAX_LETTERS; p++) begin : g_stage
        puf_stage #(.MAX_LETTERS(MAX_LETTERS), .POS(p)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctrl  (ctrl[p]),
            .i_rank  (rank[p]),
            .i_pool  (pool[p]),
            .i_res   (res[p]),
            .o_ctrl  (ctrl[p+1]),
            .o_rank  (rank[p+1]),
            .o_pool  (pool[p+1]),
            .o_res   (res[p+1])
        );
    end

    assign o_valid      = ctrl[MAX_LETTERS].vld;
    assign o_valid_res  = ctrl[MAX_LETTERS].ok;
    assign o_out_length = ctrl[MAX_LETTERS].ok ? ctrl[MAX_LETTERS].len : '0;
    assign o_permuted   = WORD_W'(res[MAX_LETTERS]);

    `PUF_ASSERT_SAME(a_reject_clear, o_valid && !o_valid_res, o_permuted == '0 && o_out_length == '0)
    `PUF_ASSERT_SAME(a_len_range, o_valid && o_valid_res, o_out_length != '0 && o_out_length <= LEN_W'(MAX_LETTERS))
    `PUF_ASSERT_NEXT(a_stall_holds, !o_ready, o_valid)

endmodule
`default_nettype wire
